>>> rtl/core/disparity_to_xyz_point_core_assert.svh
// Assertion macros for the disparity to XYZ point core.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef DISPARITY_TO_XYZ_POINT_CORE_ASSERT_SVH
`define DISPARITY_TO_XYZ_POINT_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DXP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define DXP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/dxp_pkg.sv
// Package for the disparity to XYZ point core: codes, widths, helpers.
// No dependencies.
`timescale 1ns / 1ps

package dxp_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_BASELINE     = 3'd0,
    REG_FOCAL_LENGTH = 3'd1,
    REG_DISP_THRESH  = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4,
    REG_CAM_OFFSET_X = 3'd5,
    REG_CAM_OFFSET_Z = 3'd6,
    REG_UNUSED       = 3'd7
  } reg_idx_t;

  // camera direction codes
  typedef enum logic [1:0] {
    DIR_FRONT = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_BACK  = 2'd2,
    DIR_LEFT  = 2'd3
  } view_dir_t;

  // divider geometry: 40-bit dividend, 16-bit divisor, 33 quotient bits
  localparam int DIV_NW  = 40;
  localparam int DIV_DW  = 16;
  localparam int DIV_QW  = 33;
  localparam int DIV_LAT = DIV_QW + 1;

  // side information that travels along the divider
  typedef struct packed {
    logic      vld;
    logic      ptv;
    view_dir_t dir;
    logic      sx;
    logic      sy;
    logic      zx;
    logic      zy;
    logic      dzero;
  } side_t;

  // saturate a 37-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v[36:31] == 6'b000000 || v[36:31] == 6'b111111) begin
      r = v[31:0];
    end else if (v[36]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/dxp_if.sv
// Handshake channels of the disparity to XYZ point core.
// Depends on nothing.
`timescale 1ns / 1ps

// pixel input channel
interface dxp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] disparity;
  logic [11:0] row;
  logic [11:0] col;
  logic [1:0]  view_dir;
  modport source (output valid, disparity, row, col, view_dir, input ready);
  modport sink (input valid, disparity, row, col, view_dir, output ready);
endinterface

// point output channel
interface dxp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               point_valid;
  modport source (output valid, point_x, point_y, point_z, point_valid, input ready);
  modport sink (input valid, point_x, point_y, point_z, point_valid, output ready);
endinterface

// register write channel
interface dxp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/dxp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on dxp_pkg.
`timescale 1ns / 1ps

module dxp_div
  import dxp_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic [DIV_QW-1:0] quo,
  output logic              ovf
);

  localparam int HW = DIV_NW - DIV_QW;

  logic [DIV_DW-1:0] rem_r [0:DIV_QW];
  logic [DIV_QW-1:0] num_r [0:DIV_QW];
  logic [DIV_QW-1:0] quo_r [0:DIV_QW];
  logic [DIV_DW-1:0] den_r [0:DIV_QW];
  logic              ovf_r [0:DIV_QW];

  logic [HW-1:0]     hi;
  logic              ovf_nxt;

  // entry: high dividend bits decide overflow (quotient of 2^33 or more)
  always_comb begin
    hi = num[DIV_NW-1:DIV_QW];
    if (den == '0) begin
      ovf_nxt = (num != '0);
    end else begin
      ovf_nxt = (DIV_DW'(hi) >= den);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= ovf_nxt ? '0 : DIV_DW'(hi);
      num_r[0] <= num[DIV_QW-1:0];
      quo_r[0] <= '0;
      den_r[0] <= den;
      ovf_r[0] <= ovf_nxt;
    end
  end

  // one restoring step per stage
  for (genvar k = 0; k < DIV_QW; k++) begin : g_step
    logic [DIV_DW:0] trial;
    logic            ge;
    logic [DIV_DW:0] diff;

    always_comb begin
      trial = {rem_r[k], num_r[k][DIV_QW-1]};
      ge    = (trial >= {1'b0, den_r[k]});
      diff  = trial - {1'b0, den_r[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        num_r[k+1] <= {num_r[k][DIV_QW-2:0], 1'b0};
        quo_r[k+1] <= {quo_r[k][DIV_QW-2:0], ge};
        den_r[k+1] <= den_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign quo = quo_r[DIV_QW];
  assign ovf = ovf_r[DIV_QW];

endmodule

>>> rtl/core/disparity_to_xyz_point_core.sv
// Throughput: one word per cycle while the output is not stalled.
// The 34-stage divider pipelines set the depth.
// A stall at the output holds the whole pipeline in place until the word is taken.
// Reset (rst_n low, synchronous) clears all valid bits and loads register defaults.
// Depends on dxp_pkg, dxp_if and dxp_div; assertion macros from the .svh header.
`timescale 1ns / 1ps

`include "disparity_to_xyz_point_core_assert.svh"

module disparity_to_xyz_point_core
  import dxp_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  dxp_in_if.sink    in_port,
  dxp_out_if.source out_port,
  dxp_cfg_if.sink   cfg_port
);

  // configuration registers
  logic [23:0]        baseline_r;
  logic [23:0]        focal_r;
  logic [15:0]        thresh_r;
  logic [12:0]        img_w_r;
  logic [12:0]        img_h_r;
  logic signed [23:0] off_x_r;
  logic signed [23:0] off_z_r;

  assign cfg_port.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r <= 24'd65536;
      focal_r    <= 24'd65536;
      thresh_r   <= 16'd16;
      img_w_r    <= 13'd640;
      img_h_r    <= 13'd480;
      off_x_r    <= '0;
      off_z_r    <= '0;
    end else if (cfg_port.valid) begin
      unique case (reg_idx_t'(cfg_port.index))
        REG_BASELINE:     baseline_r <= cfg_port.data;
        REG_FOCAL_LENGTH: focal_r    <= cfg_port.data;
        REG_DISP_THRESH:  thresh_r   <= cfg_port.data[15:0];
        REG_IMAGE_WIDTH:  img_w_r    <= cfg_port.data[12:0];
        REG_IMAGE_HEIGHT: img_h_r    <= cfg_port.data[12:0];
        REG_CAM_OFFSET_X: off_x_r    <= cfg_port.data;
        REG_CAM_OFFSET_Z: off_z_r    <= cfg_port.data;
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves when the output register is free or taken
  logic out_vld_r;
  logic adv;
  logic acc;

  assign adv           = !out_vld_r || out_port.ready;
  assign in_port.ready = adv;
  assign acc           = in_port.valid && adv;

  // stage 1: input register
  logic        s1_vld_r;
  logic [15:0] s1_disp_r;
  logic [11:0] s1_row_r;
  logic [11:0] s1_col_r;
  view_dir_t   s1_dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_disp_r <= in_port.disparity;
      s1_row_r  <= in_port.row;
      s1_col_r  <= in_port.col;
      s1_dir_r  <= view_dir_t'(in_port.view_dir);
    end
  end

  // stage 2: pixel offsets from the image centre, threshold test
  logic [12:0]        w_c;
  logic [12:0]        h_c;
  logic signed [13:0] offx;
  logic signed [13:0] offy;
  logic [13:0]        offx_neg;
  logic [13:0]        offy_neg;

  always_comb begin
    w_c      = (int'(img_w_r) > MAX_DIM) ? 13'(MAX_DIM) : img_w_r;
    h_c      = (int'(img_h_r) > MAX_DIM) ? 13'(MAX_DIM) : img_h_r;
    offx     = $signed({1'b0, s1_col_r, 1'b0}) - $signed({1'b0, w_c});
    offy     = $signed({1'b0, h_c}) - $signed({1'b0, s1_row_r, 1'b0});
    offx_neg = -offx;
    offy_neg = -offy;
  end

  logic        s2_vld_r;
  logic        s2_ptv_r;
  view_dir_t   s2_dir_r;
  logic [15:0] s2_disp_r;
  logic [12:0] s2_ax_r;
  logic [12:0] s2_ay_r;
  logic        s2_sx_r;
  logic        s2_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ptv_r  <= (s1_disp_r >= thresh_r);
      s2_dir_r  <= s1_dir_r;
      s2_disp_r <= s1_disp_r;
      s2_sx_r   <= offx[13];
      s2_sy_r   <= offy[13];
      s2_ax_r   <= offx[13] ? offx_neg[12:0] : offx[12:0];
      s2_ay_r   <= offy[13] ? offy_neg[12:0] : offy[12:0];
    end
  end

  // stage 3: products with the baseline
  logic        s3_vld_r;
  logic        s3_ptv_r;
  view_dir_t   s3_dir_r;
  logic [15:0] s3_disp_r;
  logic        s3_sx_r;
  logic        s3_sy_r;
  logic        s3_zx_r;
  logic        s3_zy_r;
  logic [36:0] s3_mx_r;
  logic [36:0] s3_my_r;
  logic [47:0] s3_fb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ptv_r  <= s2_ptv_r;
      s3_dir_r  <= s2_dir_r;
      s3_disp_r <= s2_disp_r;
      s3_sx_r   <= s2_sx_r;
      s3_sy_r   <= s2_sy_r;
      s3_zx_r   <= (s2_ax_r == '0);
      s3_zy_r   <= (s2_ay_r == '0);
      s3_mx_r   <= 37'(s2_ax_r) * 37'(baseline_r);
      s3_my_r   <= 37'(s2_ay_r) * 37'(baseline_r);
      s3_fb_r   <= 48'(focal_r) * 48'(baseline_r);
    end
  end

  // divider stages: magnitudes divided by disparity
  logic [DIV_NW-1:0] num_x;
  logic [DIV_NW-1:0] num_y;
  logic [DIV_NW-1:0] num_z;
  logic [DIV_QW-1:0] q_x;
  logic [DIV_QW-1:0] q_y;
  logic [DIV_QW-1:0] q_z;
  logic              ovf_x;
  logic              ovf_y;
  logic              ovf_z;

  assign num_x = {s3_mx_r, 3'b000};
  assign num_y = {s3_my_r, 3'b000};
  assign num_z = DIV_NW'(s3_fb_r[47:12]);

  dxp_div u_div_x (.clk(clk), .en(adv), .num(num_x), .den(s3_disp_r), .quo(q_x), .ovf(ovf_x));
  dxp_div u_div_y (.clk(clk), .en(adv), .num(num_y), .den(s3_disp_r), .quo(q_y), .ovf(ovf_y));
  dxp_div u_div_z (.clk(clk), .en(adv), .num(num_z), .den(s3_disp_r), .quo(q_z), .ovf(ovf_z));

  // side information delayed alongside the dividers
  side_t sb_r [0:DIV_LAT-1];
  side_t sb_in;
  side_t sb_end;

  always_comb begin
    sb_in.vld   = s3_vld_r;
    sb_in.ptv   = s3_ptv_r;
    sb_in.dir   = s3_dir_r;
    sb_in.sx    = s3_sx_r;
    sb_in.sy    = s3_sy_r;
    sb_in.zx    = s3_zx_r;
    sb_in.zy    = s3_zy_r;
    sb_in.dzero = (s3_disp_r == '0);
    sb_end      = sb_r[DIV_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        sb_r[i] <= '0;
      end
    end else if (adv) begin
      sb_r[0] <= sb_in;
      for (int i = 1; i < DIV_LAT; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  // post stage: sign, saturation flag, camera offsets
  // zero disparity: a nonzero pixel offset is infinite, a zero offset stays zero
  logic               z_ovf;
  logic [33:0]        mag_x;
  logic [33:0]        mag_y;
  logic [33:0]        mag_z;
  logic signed [34:0] sx_val;
  logic signed [34:0] sy_val;
  logic signed [35:0] x_sum;
  logic signed [35:0] z_sum;

  always_comb begin
    z_ovf  = ovf_z || sb_end.dzero;
    if (sb_end.dzero) begin
      mag_x = sb_end.zx ? 34'h0 : 34'h2_0000_0000;
      mag_y = sb_end.zy ? 34'h0 : 34'h2_0000_0000;
    end else begin
      mag_x = ovf_x ? 34'h2_0000_0000 : {1'b0, q_x};
      mag_y = ovf_y ? 34'h2_0000_0000 : {1'b0, q_y};
    end
    mag_z  = z_ovf ? 34'h2_0000_0000 : {1'b0, q_z};
    sx_val = sb_end.sx ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
    sy_val = sb_end.sy ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
    x_sum  = 36'(sx_val) + 36'(off_x_r);
    z_sum  = $signed({2'b00, mag_z}) + 36'(off_z_r);
  end

  logic               p_vld_r;
  logic               p_ptv_r;
  view_dir_t          p_dir_r;
  logic signed [35:0] p_x_r;
  logic signed [34:0] p_y_r;
  logic signed [35:0] p_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (adv) begin
      p_vld_r <= sb_end.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ptv_r <= sb_end.ptv;
      p_dir_r <= sb_end.dir;
      p_x_r   <= x_sum;
      p_y_r   <= sy_val;
      p_z_r   <= z_sum;
    end
  end

  // output stage: rotate by view direction, saturate, zero invalid points
  logic signed [36:0] ext_x;
  logic signed [36:0] ext_z;
  logic signed [36:0] rot_x;
  logic signed [36:0] rot_z;
  logic signed [31:0] px_nxt;
  logic signed [31:0] py_nxt;
  logic signed [31:0] pz_nxt;

  always_comb begin
    ext_x = 37'(p_x_r);
    ext_z = 37'(p_z_r);
    unique case (p_dir_r)
      DIR_RIGHT: begin
        rot_x = ext_z;
        rot_z = -ext_x;
      end
      DIR_BACK: begin
        rot_x = -ext_x;
        rot_z = -ext_z;
      end
      DIR_LEFT: begin
        rot_x = -ext_z;
        rot_z = ext_x;
      end
      default: begin
        rot_x = ext_x;
        rot_z = ext_z;
      end
    endcase
    px_nxt = p_ptv_r ? sat32(rot_x) : '0;
    py_nxt = p_ptv_r ? sat32(37'(p_y_r)) : '0;
    pz_nxt = p_ptv_r ? sat32(rot_z) : '0;
  end

  logic signed [31:0] px_r;
  logic signed [31:0] py_r;
  logic signed [31:0] pz_r;
  logic               ptv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      pz_r  <= pz_nxt;
      ptv_r <= p_ptv_r;
    end
  end

  assign out_port.valid       = out_vld_r;
  assign out_port.point_x     = px_r;
  assign out_port.point_y     = py_r;
  assign out_port.point_z     = pz_r;
  assign out_port.point_valid = ptv_r;

  // checks
  `DXP_ASSERT_NOW(a_invalid_is_origin, out_vld_r && !ptv_r, px_r == 0 && py_r == 0 && pz_r == 0, "invalid point not at origin")
  `DXP_ASSERT_NOW(a_zero_disp_sat, sb_end.vld && sb_end.dzero, z_ovf && mag_z == 34'h2_0000_0000, "zero disparity depth not saturated")
  `DXP_ASSERT_NEXT(a_stall_holds, !adv && s3_vld_r, s3_vld_r && $stable(s3_disp_r), "pipeline moved during stall")

endmodule
